### hw/rtl/pvb_pkg.sv
package pvb_pkg;

  localparam int STEP_W   = 16;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;

  localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLASSIFY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_STEP_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_Z = 2'd2;

endpackage

### hw/rtl/pvb_div.sv
module pvb_div #(
  parameter int NUM_W = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [NUM_W-1:0]                num,
  input  logic [pvb_pkg::STEP_W-1:0]      den,
  output logic [NUM_W-1:0]                quo,
  output logic                            done
);

  localparam int CNT_BITS = $clog2(NUM_W + 1);

  logic                         busy;
  logic [CNT_BITS-1:0]          cnt;
  logic [pvb_pkg::STEP_W-1:0]   rem;
  logic [pvb_pkg::STEP_W-1:0]   den_q;
  logic [pvb_pkg::STEP_W:0]     shifted;
  logic                         ge;
  logic [pvb_pkg::STEP_W:0]     diff;

  assign shifted = {rem, quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[pvb_pkg::STEP_W-1:0] : shifted[pvb_pkg::STEP_W-1:0];
    end
  end

endmodule

### hw/rtl/point_voxel_binning.sv
// Bounding-box voxel binner. Clear and add transfers need no division; a
// classify transfer runs six divisions (three cell counts, then three cell
// positions) through one restoring divider that retires one quotient bit per
// cycle, then three steps (two products on one multiplier, then an add) for
// the linear index. The divider works on NUM_W = max(COORD_BITS, 16) + 1 bits.
// A classify outside the box stops after the three cell counts. The divider
// sets the pace; the block takes no new item while it works on one.
module point_voxel_binning #(
  parameter int COORD_BITS     = 24,
  parameter int MAX_CELLS_AXIS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // coord_x, coord_y, coord_z, zero padding
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // action
  input  logic [pvb_pkg::ACT_W-1:0]            s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // cell_x, cell_y, cell_z, voxel_index, count_x, count_y, count_z, zero padding
  output logic [((3*$clog2(MAX_CELLS_AXIS)*2+3*$clog2(MAX_CELLS_AXIS+1)+7)/8)*8-1:0] m_tdata,
  // status
  output logic [pvb_pkg::STATUS_W-1:0]         m_tuser,
  input  logic                                 cfg_we,
  input  logic [pvb_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [pvb_pkg::STEP_W-1:0]           cfg_data
);

  localparam int C      = COORD_BITS;
  localparam int CELL_W = $clog2(MAX_CELLS_AXIS);
  localparam int CNT_W  = $clog2(MAX_CELLS_AXIS + 1);
  localparam int IDX_W  = 3 * CELL_W;
  localparam int NUM_W  = ((C > pvb_pkg::STEP_W) ? C : pvb_pkg::STEP_W) + 1;
  localparam int PROD_W = 3 * CNT_W;
  localparam int OUT_TDATA_W = ((2*IDX_W + 3*CNT_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_GO   = 3'd1;
  localparam logic [2:0] S_DIV_WAIT = 3'd2;
  localparam logic [2:0] S_MUL1     = 3'd3;
  localparam logic [2:0] S_MUL2     = 3'd4;
  localparam logic [2:0] S_MUL3     = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] phase;

  logic [pvb_pkg::STEP_W-1:0] step_x, step_y, step_z;
  logic signed [C-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [C-1:0] box_max_x, box_max_y, box_max_z;
  logic                box_valid;
  logic signed [C-1:0] pt_x, pt_y, pt_z;

  logic signed [C-1:0] in_x, in_y, in_z;
  logic                outside;
  logic                outside_q;

  logic [pvb_pkg::STATUS_W-1:0] res_status;
  logic [CELL_W-1:0] res_cell_x, res_cell_y, res_cell_z;
  logic [CNT_W-1:0]  res_cnt_x, res_cnt_y, res_cnt_z;
  logic [IDX_W-1:0]  res_idx;

  logic signed [C-1:0]        sub_hi, sub_lo;
  logic [pvb_pkg::STEP_W-1:0] sel_step, step_eff;
  logic [CNT_W-1:0]           sel_cnt;
  logic [C:0]                 sub_full;
  logic [C-1:0]               sub_val;
  logic [NUM_W-1:0]           div_num;
  logic [NUM_W-1:0]           div_quo;
  logic                       div_start;
  logic                       div_done;
  logic [CNT_W-1:0]           cnt_clamped;
  logic [CELL_W-1:0]          cell_clamped;
  logic [NUM_W-1:0]           cnt_m1;

  logic [CNT_W-1:0]   mul_a;
  logic [2*CNT_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  idx_sum;

  logic out_free;

  assign in_x = s_tdata[C-1:0];
  assign in_y = s_tdata[2*C-1:C];
  assign in_z = s_tdata[3*C-1:2*C];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign outside = (in_x < box_min_x) || (in_x > box_max_x) ||
                   (in_y < box_min_y) || (in_y > box_max_y) ||
                   (in_z < box_min_z) || (in_z > box_max_z);

  always_comb begin
    case (phase)
      3'd0: begin
        sub_hi = box_max_x; sub_lo = box_min_x; sel_step = step_x; sel_cnt = res_cnt_x;
      end
      3'd1: begin
        sub_hi = box_max_y; sub_lo = box_min_y; sel_step = step_y; sel_cnt = res_cnt_y;
      end
      3'd2: begin
        sub_hi = box_max_z; sub_lo = box_min_z; sel_step = step_z; sel_cnt = res_cnt_z;
      end
      3'd3: begin
        sub_hi = pt_x; sub_lo = box_min_x; sel_step = step_x; sel_cnt = res_cnt_x;
      end
      3'd4: begin
        sub_hi = pt_y; sub_lo = box_min_y; sel_step = step_y; sel_cnt = res_cnt_y;
      end
      default: begin
        sub_hi = pt_z; sub_lo = box_min_z; sel_step = step_z; sel_cnt = res_cnt_z;
      end
    endcase
  end

  assign step_eff = (sel_step == '0) ? pvb_pkg::STEP_W'(1) : sel_step;
  assign sub_full = {sub_hi[C-1], sub_hi} - {sub_lo[C-1], sub_lo};
  assign sub_val  = sub_full[C-1:0];

  always_comb begin
    if (phase < 3'd3) begin
      div_num = NUM_W'(sub_val) + NUM_W'(step_eff) - NUM_W'(1);
    end else if (sub_val == '0) begin
      div_num = '0;
    end else begin
      div_num = NUM_W'(sub_val) - NUM_W'(1);
    end
  end

  assign div_start = (state == S_DIV_GO);

  pvb_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (step_eff),
    .quo  (div_quo),
    .done (div_done)
  );

  always_comb begin
    if (div_quo == '0) begin
      cnt_clamped = CNT_W'(1);
    end else if (div_quo > NUM_W'(MAX_CELLS_AXIS)) begin
      cnt_clamped = CNT_W'(MAX_CELLS_AXIS);
    end else begin
      cnt_clamped = div_quo[CNT_W-1:0];
    end
  end

  assign cnt_m1 = NUM_W'(sel_cnt) - NUM_W'(1);
  assign cell_clamped = (div_quo > cnt_m1) ? cnt_m1[CELL_W-1:0] : div_quo[CELL_W-1:0];

  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = res_cnt_y;
        mul_b = (2*CNT_W)'(res_cell_z);
      end
      default: begin
        mul_a = res_cnt_x;
        mul_b = (2*CNT_W)'(res_cell_y) + prod[2*CNT_W-1:0];
      end
    endcase
  end

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign idx_sum = prod + PROD_W'(res_cell_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x <= pvb_pkg::STEP_RESET;
      step_y <= pvb_pkg::STEP_RESET;
      step_z <= pvb_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pvb_pkg::REG_STEP_X: step_x <= cfg_data;
        pvb_pkg::REG_STEP_Y: step_y <= cfg_data;
        pvb_pkg::REG_STEP_Z: step_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      box_valid <= 1'b0;
      box_min_x <= '0;
      box_min_y <= '0;
      box_min_z <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
      box_max_z <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DONE;
            case (s_tuser)
              pvb_pkg::ACT_CLEAR: begin
                box_valid <= 1'b0;
                box_min_x <= '0;
                box_min_y <= '0;
                box_min_z <= '0;
                box_max_x <= '0;
                box_max_y <= '0;
                box_max_z <= '0;
              end
              pvb_pkg::ACT_ADD: begin
                box_valid <= 1'b1;
                if (!box_valid || in_x < box_min_x) box_min_x <= in_x;
                if (!box_valid || in_x > box_max_x) box_max_x <= in_x;
                if (!box_valid || in_y < box_min_y) box_min_y <= in_y;
                if (!box_valid || in_y > box_max_y) box_max_y <= in_y;
                if (!box_valid || in_z < box_min_z) box_min_z <= in_z;
                if (!box_valid || in_z > box_max_z) box_max_z <= in_z;
              end
              pvb_pkg::ACT_CLASSIFY: begin
                if (box_valid) begin
                  phase <= '0;
                  state <= S_DIV_GO;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            phase <= phase + 3'd1;
            if (phase == 3'd2 && outside_q) begin
              state <= S_DONE;
            end else if (phase == 3'd5) begin
              state <= S_MUL1;
            end else begin
              state <= S_DIV_GO;
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pt_x       <= in_x;
        pt_y       <= in_y;
        pt_z       <= in_z;
        outside_q  <= outside;
        res_cell_x <= '0;
        res_cell_y <= '0;
        res_cell_z <= '0;
        res_cnt_x  <= '0;
        res_cnt_y  <= '0;
        res_cnt_z  <= '0;
        res_idx    <= '0;
        if (s_tuser == pvb_pkg::ACT_CLASSIFY) begin
          if (!box_valid) begin
            res_status <= pvb_pkg::ST_EMPTY;
          end else if (outside) begin
            res_status <= pvb_pkg::ST_OUTSIDE;
          end else begin
            res_status <= pvb_pkg::ST_OK;
          end
        end else begin
          res_status <= pvb_pkg::ST_OK;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (phase)
            3'd0: res_cnt_x <= cnt_clamped;
            3'd1: res_cnt_y <= cnt_clamped;
            3'd2: res_cnt_z <= cnt_clamped;
            3'd3: res_cell_x <= cell_clamped;
            3'd4: res_cell_y <= cell_clamped;
            default: res_cell_z <= cell_clamped;
          endcase
        end
      end
      S_MUL1, S_MUL2: prod <= mul_p;
      S_MUL3: res_idx <= idx_sum[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tuser <= res_status;
      m_tdata <= OUT_TDATA_W'({res_cnt_z, res_cnt_y, res_cnt_x, res_idx,
                               res_cell_z, res_cell_y, res_cell_x});
    end
  end

endmodule

### hw/rtl/pvb_checker.sv
module pvb_checker #(
  parameter int MAX_CELLS_AXIS = 1024
) (
  input logic clk,
  input logic rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((3*$clog2(MAX_CELLS_AXIS)*2+3*$clog2(MAX_CELLS_AXIS+1)+7)/8)*8-1:0] m_tdata,
  input logic [pvb_pkg::STATUS_W-1:0]         m_tuser
);

  localparam int IDX_W = 3 * $clog2(MAX_CELLS_AXIS);

  // The block works on one item at a time, so a transfer in drops ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready stayed high after a transfer");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pvb_pkg::ST_EMPTY) |-> (m_tdata == '0))
    else $error("empty-box result carries data");

  a_outside_no_cell: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pvb_pkg::ST_OUTSIDE) |-> (m_tdata[2*IDX_W-1:0] == '0))
    else $error("outside result carries a cell");

endmodule

bind point_voxel_binning pvb_checker #(
  .MAX_CELLS_AXIS(MAX_CELLS_AXIS)
) u_pvb_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
